/* rtl/rgfub_pkg.sv */
// Package for the RS-485 gap-framed UART buffer: buffer sizing, request kinds,
// configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgfub_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	// Transmit counters must hold BUF_DEPTH itself
	localparam int CNT_W     = ADDR_W + 1;

	typedef enum logic [2:0] {
		REQ_RX_BYTE    = 3'd0,
		REQ_TICK       = 3'd1,
		REQ_TX_APPEND  = 3'd2,
		REQ_TX_SLOT    = 3'd3,
		REQ_TX_DONE    = 3'd4,
		REQ_RX_RELEASE = 3'd5,
		REQ_READ       = 3'd6,
		REQ_NONE       = 3'd7
	} req_kind_t;

	localparam logic [1:0] CFG_GAP_TIMEOUT   = 2'd0;
	localparam logic [1:0] CFG_ALIVE_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_SHORT_LEN     = 2'd2;

	localparam logic [7:0]  GAP_TIMEOUT_RST   = 8'd5;
	localparam logic [15:0] ALIVE_TIMEOUT_RST = 16'd2000;
	localparam logic [5:0]  SHORT_LEN_RST     = 6'd8;

endpackage

`default_nettype wire

/* rtl/rgfub_ram.sv */
// Generic single-port synchronous RAM, one access per cycle, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgfub_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds when no read is issued
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rs485_gap_framed_uart_buffer.sv */
// Top level of the RS-485 gap-framed UART buffer: request decode, timers,
// counters and a two-stage result path around the shared byte memory.
// Depends on rgfub_pkg and rgfub_ram.
//
//  channel  dir  handshake               payload
//  -------  ---  ----------------------  ------------------------------------------
//  s_axis   in   s_tvalid / s_tready     tdata {read_index, data_byte}, tuser req_type,
//                                        tlast append_last
//  m_axis   out  m_tvalid / m_tready     tdata: one status/result item per request
//  cfg      in   cfg_valid / cfg_ready   cfg_index (register), cfg_data
//
// One request item per cycle sustained while m_axis is not stalled. An accepted item
// passes stage 1 and then the output register: stage 1 is the memory access (single
// port, one read or write per item), the output register then takes the registered
// read data. Stalls on m_axis back up through stage 1 to s_tready; the memory read
// data holds while stalled. Reset clears all counters, timers and flags and loads
// the register defaults; the byte memory is not cleared. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module rs485_gap_framed_uart_buffer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] read_index, [15:14] zero
	input  wire logic [2:0]  s_tuser,   // [2:0] req_type
	input  wire logic        s_tlast,   // append_last

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [0] tx_valid, [8:1] tx_byte, [9] driver_enable,
	                                    // [10] frame_done, [11] short_frame,
	                                    // [17:12] rx_count, [18] line_alive,
	                                    // [26:19] read_data, [31:27] zero

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = rgfub_pkg::ADDR_W;
	localparam int CW = rgfub_pkg::CNT_W;

	// ---------------- configuration ----------------
	logic [7:0]  gap_to_q;
	logic [15:0] alive_to_q;
	logic [5:0]  short_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_to_q    <= rgfub_pkg::GAP_TIMEOUT_RST;
			alive_to_q  <= rgfub_pkg::ALIVE_TIMEOUT_RST;
			short_len_q <= rgfub_pkg::SHORT_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgfub_pkg::CFG_GAP_TIMEOUT:   gap_to_q    <= cfg_data[7:0];
				rgfub_pkg::CFG_ALIVE_TIMEOUT: alive_to_q  <= cfg_data;
				rgfub_pkg::CFG_SHORT_LEN:     short_len_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ---------------- request fields ----------------
	rgfub_pkg::req_kind_t kind;
	logic [7:0]           in_byte;
	logic [5:0]           in_ridx;
	logic                 in_fire;

	assign kind    = rgfub_pkg::req_kind_t'(s_tuser);
	assign in_byte = s_tdata[7:0];
	assign in_ridx = s_tdata[13:8];
	// append_last marks request ends only; it steers nothing here
	logic unused_last;
	assign unused_last = s_tlast;

	// ---------------- block state ----------------
	logic [AW-1:0] recv_q;
	logic [7:0]    gap_q;
	logic [15:0]   alive_q;
	logic          frame_q;
	logic          short_q;
	logic [CW-1:0] queued_q;
	logic [CW-1:0] sent_q;
	logic          busy_q;

	logic [AW-1:0] recv_d;
	logic [7:0]    gap_d;
	logic [15:0]   alive_d;
	logic          frame_d;
	logic          short_d;
	logic [CW-1:0] queued_d;
	logic [CW-1:0] sent_d;
	logic          busy_d;

	// memory port
	logic          mem_en;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	// per-item result steering
	logic          txv_d;
	logic [7:0]    txb_d;
	logic          tx_from_mem_d;
	logic          rd_from_mem_d;

	// widened views for compares against 6-bit fields
	logic [AW+5:0] recv_next_ext;
	logic [AW+5:0] short_ext;
	logic [AW+5:0] ridx_ext;
	logic [AW-1:0] recv_inc;

	assign recv_inc      = recv_q + AW'(1);
	assign recv_next_ext = {6'd0, recv_inc};
	assign short_ext     = {{AW{1'b0}}, short_len_q};
	assign ridx_ext      = {{AW{1'b0}}, in_ridx};

	always_comb begin
		recv_d        = recv_q;
		gap_d         = gap_q;
		alive_d       = alive_q;
		frame_d       = frame_q;
		short_d       = short_q;
		queued_d      = queued_q;
		sent_d        = sent_q;
		busy_d        = busy_q;
		mem_en        = 1'b0;
		mem_we        = 1'b0;
		mem_addr      = '0;
		mem_wdata     = in_byte;
		txv_d         = 1'b0;
		txb_d         = 8'd0;
		tx_from_mem_d = 1'b0;
		rd_from_mem_d = 1'b0;

		case (kind)
			rgfub_pkg::REQ_RX_BYTE: begin
				alive_d = alive_to_q;
				if (!frame_q) begin
					gap_d = gap_to_q;
					if (recv_q != AW'(rgfub_pkg::BUF_DEPTH - 1)) begin
						mem_en   = 1'b1;
						mem_we   = 1'b1;
						mem_addr = recv_q;
						recv_d   = recv_inc;
						if (recv_next_ext == short_ext) begin
							short_d = 1'b1;
						end
						if (recv_inc == AW'(rgfub_pkg::BUF_DEPTH - 1)) begin
							frame_d = 1'b1;
						end
					end
				end
			end
			rgfub_pkg::REQ_TICK: begin
				if (gap_q != 8'd0) begin
					gap_d = gap_q - 8'd1;
					if (gap_q == 8'd1 && recv_q != '0) begin
						frame_d = 1'b1;
					end
				end
				if (alive_q != 16'd0) begin
					alive_d = alive_q - 16'd1;
				end
			end
			rgfub_pkg::REQ_TX_APPEND: begin
				if (!busy_q) begin
					// first byte of a burst goes out at once and is counted as sent
					busy_d   = 1'b1;
					mem_en   = 1'b1;
					mem_we   = 1'b1;
					mem_addr = '0;
					queued_d = CW'(1);
					sent_d   = CW'(1);
					txv_d    = 1'b1;
					txb_d    = in_byte;
				end else if (queued_q < CW'(rgfub_pkg::BUF_DEPTH)) begin
					mem_en   = 1'b1;
					mem_we   = 1'b1;
					mem_addr = queued_q[AW-1:0];
					queued_d = queued_q + CW'(1);
				end
			end
			rgfub_pkg::REQ_TX_SLOT: begin
				if (busy_q && sent_q < queued_q && sent_q < CW'(rgfub_pkg::BUF_DEPTH)) begin
					mem_en        = 1'b1;
					mem_addr      = sent_q[AW-1:0];
					sent_d        = sent_q + CW'(1);
					txv_d         = 1'b1;
					tx_from_mem_d = 1'b1;
				end
			end
			rgfub_pkg::REQ_TX_DONE: begin
				busy_d = 1'b0;
			end
			rgfub_pkg::REQ_RX_RELEASE: begin
				recv_d  = '0;
				gap_d   = 8'd0;
				frame_d = 1'b0;
				short_d = 1'b0;
			end
			rgfub_pkg::REQ_READ: begin
				if (ridx_ext < (AW + 6)'(rgfub_pkg::BUF_DEPTH)) begin
					mem_en        = 1'b1;
					mem_addr      = ridx_ext[AW-1:0];
					rd_from_mem_d = 1'b1;
				end
			end
			default: ;
		endcase

		// no memory access unless the item is actually taken
		mem_en = mem_en & in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q   <= '0;
			gap_q    <= 8'd0;
			alive_q  <= 16'd0;
			frame_q  <= 1'b0;
			short_q  <= 1'b0;
			queued_q <= '0;
			sent_q   <= '0;
			busy_q   <= 1'b0;
		end else if (in_fire) begin
			recv_q   <= recv_d;
			gap_q    <= gap_d;
			alive_q  <= alive_d;
			frame_q  <= frame_d;
			short_q  <= short_d;
			queued_q <= queued_d;
			sent_q   <= sent_d;
			busy_q   <= busy_d;
		end
	end

	rgfub_ram #(
		.WIDTH (8),
		.DEPTH (rgfub_pkg::BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// ---------------- stage 1: memory access in flight ----------------
	logic          valid_s1;
	logic          txv_s1;
	logic [7:0]    txb_s1;
	logic          tx_from_mem_s1;
	logic          rd_from_mem_s1;
	logic          busy_s1;
	logic          frame_s1;
	logic          short_s1;
	logic [5:0]    rxcnt_s1;
	logic          alive_s1;
	logic [AW+5:0] recv_d_ext;
	logic          adv_s1;

	logic          out_valid_q;

	assign recv_d_ext = {6'd0, recv_d};
	assign adv_s1     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || adv_s1;
	assign in_fire    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			txv_s1         <= txv_d;
			txb_s1         <= txb_d;
			tx_from_mem_s1 <= tx_from_mem_d;
			rd_from_mem_s1 <= rd_from_mem_d;
			busy_s1        <= busy_d;
			frame_s1       <= frame_d;
			short_s1       <= short_d;
			rxcnt_s1       <= recv_d_ext[5:0];
			alive_s1       <= (alive_d != 16'd0);
		end
	end

	// ---------------- output register ----------------
	logic [31:0] out_data_q;
	logic [7:0]  tx_byte_s1;
	logic [7:0]  read_data_s1;

	assign tx_byte_s1   = tx_from_mem_s1 ? mem_rdata : txb_s1;
	assign read_data_s1 = rd_from_mem_s1 ? mem_rdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {5'd0, read_data_s1, alive_s1, rxcnt_s1, short_s1,
			               frame_s1, busy_s1, tx_byte_s1, txv_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
